// File: rtl/core/ptdw_pkg.sv
`default_nettype none

package ptdw_pkg;

    localparam int MAX_TASKS_DEF = 8;

    // command codes
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_ADD    = 3'd1;
    localparam logic [2:0] CMD_REMOVE = 3'd2;
    localparam logic [2:0] CMD_NEXT   = 3'd3;
    localparam logic [2:0] CMD_DONE   = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_FAIL        = 3'd1;
    localparam logic [2:0] ST_DISPATCHED  = 3'd2;
    localparam logic [2:0] ST_NONE        = 3'd3;
    localparam logic [2:0] ST_EXPIRED     = 3'd4;
    localparam logic [2:0] ST_NOT_RUNNING = 3'd5;

    typedef struct packed {
        logic [2:0]  command;
        logic [7:0]  task_id;
        logic        task_enabled;
        logic [15:0] period_ticks;
        logic [15:0] watchdog_ticks;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  dispatched_id;
        logic [31:0] tick_now;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  id;
        logic        enable;
        logic [15:0] period;
        logic [15:0] watchdog;
        logic [31:0] last_run;
    } entry_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_NEW,
        WR_UPDATE,
        WR_COPY,
        WR_STAMP
    } wr_kind_t;

    typedef enum logic [2:0] {
        UPD_NONE,
        UPD_TICK,
        UPD_ADD,
        UPD_REMOVE,
        UPD_DISPATCH,
        UPD_NO_DUE,
        UPD_DONE
    } upd_t;

    typedef struct packed {
        logic       capture;
        logic       rd_en;
        wr_kind_t   wr_kind;
        upd_t       upd;
        logic       emit;
        logic [2:0] status;
        logic       mark_hit;
    } ctl_t;

    typedef struct packed {
        logic running;
        logic ticked_once;
        logic count_full;
        logic slot_valid;
        logic wd_expire;
        logic id_match;
        logic due;
        logic hit_is_running;
    } sts_t;

endpackage

`default_nettype wire

// File: rtl/core/ptdw_dpath.sv
`default_nettype none

module ptdw_dpath #(
    parameter int MAX_TASKS = ptdw_pkg::MAX_TASKS_DEF,
    localparam int SLOT_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
    localparam int CNT_W    = $clog2(MAX_TASKS + 1)
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire ptdw_pkg::in_item_t      request,
    input  wire ptdw_pkg::ctl_t          ctl,
    input  wire logic [SLOT_W-1:0]       rd_addr,
    input  wire logic [SLOT_W-1:0]       wr_addr,
    output ptdw_pkg::sts_t               sts,
    output logic [CNT_W-1:0]             task_count,
    output logic [CNT_W-1:0]             scan_position,
    output logic [SLOT_W-1:0]            running_slot,
    output logic [SLOT_W-1:0]            rd_idx,
    output ptdw_pkg::out_item_t          result,
    output logic                         result_strobe
);

    ptdw_pkg::entry_t    mem [MAX_TASKS];
    ptdw_pkg::entry_t    rd_data_reg;
    logic [SLOT_W-1:0]   rd_idx_reg;
    logic [SLOT_W-1:0]   hit_idx_reg;
    ptdw_pkg::in_item_t  item_reg;
    ptdw_pkg::entry_t    wr_data;
    logic                wr_en;

    logic [31:0]         tick_count_reg, tick_count_next;
    logic                ticked_once_reg, ticked_once_next;
    logic                running_reg, running_next;
    logic [SLOT_W-1:0]   running_slot_reg, running_slot_next;
    logic [15:0]         watchdog_left_reg, watchdog_left_next;
    logic [CNT_W-1:0]    scan_position_reg, scan_position_next;
    logic [CNT_W-1:0]    task_count_reg, task_count_next;
    ptdw_pkg::out_item_t result_reg, result_next;
    logic                result_strobe_reg;
    logic [31:0]         age;

    // table memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
        if (ctl.mark_hit)
        begin
            hit_idx_reg <= rd_idx_reg;
        end
        if (ctl.capture)
        begin
            item_reg <= request;
        end
        result_reg <= result_next;
    end

    always_comb
    begin
        wr_data = rd_data_reg;
        wr_en   = 1'b1;
        case (ctl.wr_kind)
            ptdw_pkg::WR_NEW:
            begin
                wr_data.id       = item_reg.task_id;
                wr_data.enable   = item_reg.task_enabled;
                wr_data.period   = item_reg.period_ticks;
                wr_data.watchdog = item_reg.watchdog_ticks;
                wr_data.last_run = '0;
            end
            ptdw_pkg::WR_UPDATE:
            begin
                wr_data.enable = item_reg.task_enabled;
                wr_data.period = item_reg.period_ticks;
            end
            ptdw_pkg::WR_COPY:
            begin
                wr_data = rd_data_reg;
            end
            ptdw_pkg::WR_STAMP:
            begin
                wr_data.last_run = tick_count_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    assign age = tick_count_reg - rd_data_reg.last_run;

    always_comb
    begin
        sts.running        = running_reg;
        sts.ticked_once    = ticked_once_reg;
        sts.count_full     = (task_count_reg == CNT_W'(MAX_TASKS));
        sts.slot_valid     = (CNT_W'(running_slot_reg) < task_count_reg);
        sts.wd_expire      = running_reg && (watchdog_left_reg == 16'd1);
        sts.id_match       = (rd_data_reg.id == item_reg.task_id);
        sts.due            = rd_data_reg.enable && (age > {16'b0, rd_data_reg.period});
        sts.hit_is_running = running_reg && (rd_idx_reg == running_slot_reg);
    end

    always_comb
    begin
        tick_count_next    = tick_count_reg;
        ticked_once_next   = ticked_once_reg;
        running_next       = running_reg;
        running_slot_next  = running_slot_reg;
        watchdog_left_next = watchdog_left_reg;
        scan_position_next = scan_position_reg;
        task_count_next    = task_count_reg;
        case (ctl.upd)
            ptdw_pkg::UPD_TICK:
            begin
                ticked_once_next = 1'b1;
                tick_count_next  = tick_count_reg + 32'd1;
                if (running_reg)
                begin
                    watchdog_left_next = watchdog_left_reg - 16'd1;
                end
                if (sts.wd_expire)
                begin
                    // expiry puts all the scheduler registers back to their reset values
                    tick_count_next    = '0;
                    ticked_once_next   = 1'b0;
                    running_next       = 1'b0;
                    running_slot_next  = '0;
                    watchdog_left_next = '0;
                    scan_position_next = '0;
                    task_count_next    = '0;
                end
            end
            ptdw_pkg::UPD_ADD:
            begin
                task_count_next = task_count_reg + CNT_W'(1);
            end
            ptdw_pkg::UPD_REMOVE:
            begin
                task_count_next = task_count_reg - CNT_W'(1);
                if (running_reg && (running_slot_reg > hit_idx_reg))
                begin
                    running_slot_next = running_slot_reg - SLOT_W'(1);
                end
                if (scan_position_reg > CNT_W'(hit_idx_reg))
                begin
                    scan_position_next = scan_position_reg - CNT_W'(1);
                end
            end
            ptdw_pkg::UPD_DISPATCH:
            begin
                running_next       = 1'b1;
                running_slot_next  = rd_idx_reg;
                watchdog_left_next = rd_data_reg.watchdog;
                scan_position_next = CNT_W'(rd_idx_reg) + CNT_W'(1);
            end
            ptdw_pkg::UPD_NO_DUE:
            begin
                scan_position_next = '0;
            end
            ptdw_pkg::UPD_DONE:
            begin
                running_next = 1'b0;
            end
            default:
            begin
            end
        endcase

        result_next.status        = ctl.status;
        result_next.dispatched_id = (ctl.upd == ptdw_pkg::UPD_DISPATCH) ? rd_data_reg.id : 8'd0;
        result_next.tick_now      = tick_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg    <= '0;
            ticked_once_reg   <= 1'b0;
            running_reg       <= 1'b0;
            running_slot_reg  <= '0;
            watchdog_left_reg <= '0;
            scan_position_reg <= '0;
            task_count_reg    <= '0;
            result_strobe_reg <= 1'b0;
        end
        else
        begin
            tick_count_reg    <= tick_count_next;
            ticked_once_reg   <= ticked_once_next;
            running_reg       <= running_next;
            running_slot_reg  <= running_slot_next;
            watchdog_left_reg <= watchdog_left_next;
            scan_position_reg <= scan_position_next;
            task_count_reg    <= task_count_next;
            result_strobe_reg <= ctl.emit;
        end
    end

    assign task_count    = task_count_reg;
    assign scan_position = scan_position_reg;
    assign running_slot  = running_slot_reg;
    assign rd_idx        = rd_idx_reg;
    assign result        = result_reg;
    assign result_strobe = result_strobe_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        task_count_reg <= CNT_W'(MAX_TASKS))
        else $error("task count above table size");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_position_reg <= task_count_reg)
        else $error("scan position past end of table");

    a_running_slot: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> (CNT_W'(running_slot_reg) < task_count_reg))
        else $error("running task outside table");

    a_dispatch_runs: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe_reg && (result_reg.status == ptdw_pkg::ST_DISPATCHED) |-> running_reg)
        else $error("dispatch reported without a running task");

endmodule

`default_nettype wire

// File: rtl/core/ptdw_ctrl.sv
`default_nettype none

module ptdw_ctrl #(
    parameter int MAX_TASKS = ptdw_pkg::MAX_TASKS_DEF,
    localparam int SLOT_W   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
    localparam int CNT_W    = $clog2(MAX_TASKS + 1)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [2:0]            command,
    input  wire ptdw_pkg::sts_t        sts,
    input  wire logic [CNT_W-1:0]      task_count,
    input  wire logic [CNT_W-1:0]      scan_position,
    input  wire logic [SLOT_W-1:0]     running_slot,
    input  wire logic [SLOT_W-1:0]     rd_idx,
    output logic                       busy,
    output ptdw_pkg::ctl_t             ctl,
    output logic [SLOT_W-1:0]          rd_addr,
    output logic [SLOT_W-1:0]          wr_addr
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_REM,
        S_SHIFT,
        S_NEXT,
        S_DONE_WR
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             chk_valid_reg, chk_valid_next;
    logic             more;

    // ptr is the next slot to read, chk_valid marks fresh read data
    assign more = (ptr_reg < task_count);

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        chk_valid_next = chk_valid_reg;
        ctl            = '0;
        ctl.status     = ptdw_pkg::ST_OK;
        rd_addr        = ptr_reg[SLOT_W-1:0];
        wr_addr        = rd_idx;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.capture    = 1'b1;
                    chk_valid_next = 1'b0;
                    ptr_next       = '0;
                    unique case (command)
                        ptdw_pkg::CMD_TICK:
                        begin
                            ctl.upd    = ptdw_pkg::UPD_TICK;
                            ctl.emit   = 1'b1;
                            ctl.status = sts.wd_expire ? ptdw_pkg::ST_EXPIRED
                                                       : ptdw_pkg::ST_OK;
                        end
                        ptdw_pkg::CMD_ADD:
                        begin
                            state_next = S_ADD;
                        end
                        ptdw_pkg::CMD_REMOVE:
                        begin
                            state_next = S_REM;
                        end
                        ptdw_pkg::CMD_NEXT:
                        begin
                            if (sts.running)
                            begin
                                ctl.emit   = 1'b1;
                                ctl.status = ptdw_pkg::ST_FAIL;
                            end
                            else if (!sts.ticked_once)
                            begin
                                ctl.emit   = 1'b1;
                                ctl.status = ptdw_pkg::ST_NONE;
                            end
                            else
                            begin
                                ptr_next   = scan_position;
                                state_next = S_NEXT;
                            end
                        end
                        ptdw_pkg::CMD_DONE:
                        begin
                            if (!sts.running)
                            begin
                                ctl.emit   = 1'b1;
                                ctl.status = ptdw_pkg::ST_NOT_RUNNING;
                            end
                            else if (sts.slot_valid)
                            begin
                                ctl.rd_en  = 1'b1;
                                rd_addr    = running_slot;
                                state_next = S_DONE_WR;
                            end
                            else
                            begin
                                ctl.upd  = ptdw_pkg::UPD_DONE;
                                ctl.emit = 1'b1;
                            end
                        end
                        default:
                        begin
                            ctl.emit   = 1'b1;
                            ctl.status = ptdw_pkg::ST_FAIL;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                if (chk_valid_reg && sts.id_match)
                begin
                    // known id: refresh enable and period in place
                    ctl.wr_kind = ptdw_pkg::WR_UPDATE;
                    ctl.emit    = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (more)
                begin
                    ctl.rd_en      = 1'b1;
                    ptr_next       = ptr_reg + CNT_W'(1);
                    chk_valid_next = 1'b1;
                end
                else if (sts.count_full)
                begin
                    ctl.emit   = 1'b1;
                    ctl.status = ptdw_pkg::ST_FAIL;
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.wr_kind = ptdw_pkg::WR_NEW;
                    wr_addr     = task_count[SLOT_W-1:0];
                    ctl.upd     = ptdw_pkg::UPD_ADD;
                    ctl.emit    = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_REM:
            begin
                if (chk_valid_reg && sts.id_match)
                begin
                    if (sts.hit_is_running)
                    begin
                        ctl.emit   = 1'b1;
                        ctl.status = ptdw_pkg::ST_FAIL;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ctl.mark_hit   = 1'b1;
                        ptr_next       = CNT_W'(rd_idx) + CNT_W'(1);
                        chk_valid_next = 1'b0;
                        state_next     = S_SHIFT;
                    end
                end
                else if (more)
                begin
                    ctl.rd_en      = 1'b1;
                    ptr_next       = ptr_reg + CNT_W'(1);
                    chk_valid_next = 1'b1;
                end
                else
                begin
                    ctl.emit   = 1'b1;
                    ctl.status = ptdw_pkg::ST_FAIL;
                    state_next = S_IDLE;
                end
            end
            S_SHIFT:
            begin
                // entry read last cycle moves down one slot
                if (chk_valid_reg)
                begin
                    ctl.wr_kind = ptdw_pkg::WR_COPY;
                    wr_addr     = rd_idx - SLOT_W'(1);
                end
                if (more)
                begin
                    ctl.rd_en      = 1'b1;
                    ptr_next       = ptr_reg + CNT_W'(1);
                    chk_valid_next = 1'b1;
                end
                else
                begin
                    ctl.upd    = ptdw_pkg::UPD_REMOVE;
                    ctl.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_NEXT:
            begin
                if (chk_valid_reg && sts.due)
                begin
                    ctl.upd    = ptdw_pkg::UPD_DISPATCH;
                    ctl.emit   = 1'b1;
                    ctl.status = ptdw_pkg::ST_DISPATCHED;
                    state_next = S_IDLE;
                end
                else if (more)
                begin
                    ctl.rd_en      = 1'b1;
                    ptr_next       = ptr_reg + CNT_W'(1);
                    chk_valid_next = 1'b1;
                end
                else
                begin
                    ctl.upd    = ptdw_pkg::UPD_NO_DUE;
                    ctl.emit   = 1'b1;
                    ctl.status = ptdw_pkg::ST_NONE;
                    state_next = S_IDLE;
                end
            end
            S_DONE_WR:
            begin
                ctl.wr_kind = ptdw_pkg::WR_STAMP;
                ctl.upd     = ptdw_pkg::UPD_DONE;
                ctl.emit    = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/core/periodic_task_dispatcher_with_watchdog_top.sv
`default_nettype none

// Periodic task dispatcher with execution watchdog. An item is taken when start is high
// and busy is low; its single result appears on result for one cycle with result_strobe
// high and must be taken then, as the block cannot be held off. Tick, a refused next or
// done, and unused commands put their result out the cycle after the item is taken, and
// done with a running task once its entry has been read and stamped in S_DONE_WR. Add
// and next walk the task table one slot per cycle and answer when they find their entry
// or reach the end of the table. Remove answers at the end of the walk when the id is
// unknown, and after every later entry has moved down one slot when it compacts the
// table; the walk to the hit and the move read each entry once, one entry per cycle,
// through a registered read port; busy is low again in the cycle that carries the result.

module periodic_task_dispatcher_with_watchdog_top #(
    parameter int MAX_TASKS = ptdw_pkg::MAX_TASKS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire ptdw_pkg::in_item_t  request,
    output ptdw_pkg::out_item_t      result,
    output logic                     result_strobe
);

    localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W  = $clog2(MAX_TASKS + 1);

    ptdw_pkg::ctl_t    ctl;
    ptdw_pkg::sts_t    sts;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] wr_addr;
    logic [CNT_W-1:0]  task_count;
    logic [CNT_W-1:0]  scan_position;
    logic [SLOT_W-1:0] running_slot;
    logic [SLOT_W-1:0] rd_idx;

    ptdw_ctrl #(
        .MAX_TASKS (MAX_TASKS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .command       (request.command),
        .sts           (sts),
        .task_count    (task_count),
        .scan_position (scan_position),
        .running_slot  (running_slot),
        .rd_idx        (rd_idx),
        .busy          (busy),
        .ctl           (ctl),
        .rd_addr       (rd_addr),
        .wr_addr       (wr_addr)
    );

    ptdw_dpath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .request       (request),
        .ctl           (ctl),
        .rd_addr       (rd_addr),
        .wr_addr       (wr_addr),
        .sts           (sts),
        .task_count    (task_count),
        .scan_position (scan_position),
        .running_slot  (running_slot),
        .rd_idx        (rd_idx),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule

`default_nettype wire
